/* hw/rtl/rank_enumeration_sorter_core_macros.svh */
`ifndef RANK_ENUMERATION_SORTER_CORE_MACROS_SVH
`define RANK_ENUMERATION_SORTER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define RES_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define RES_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define RES_ASSERT_IMP(lbl, ante, cons)
`define RES_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* hw/rtl/res_pkg.sv */
package res_pkg;

  localparam int KEY_PORT_W = 32;

  typedef struct packed {
    logic busy;
    logic done;
  } res_rank_stat_t;

endpackage

/* hw/rtl/res_ram.sv */
module res_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/res_rank.sv */
module res_rank #(
  parameter int MAX_ITEMS = 16,
  parameter int KEY_BITS  = 32,
  localparam int IW = $clog2(MAX_ITEMS),
  localparam int CW = $clog2(MAX_ITEMS + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [CW-1:0]           count,
  output logic [IW-1:0]           key_raddr,
  input  logic [KEY_BITS-1:0]     key_rdata,
  output logic                    srt_we,
  output logic [IW-1:0]           srt_waddr,
  output logic [KEY_BITS-1:0]     srt_wdata,
  output res_pkg::res_rank_stat_t stat
);

  typedef enum logic [4:0] {
    RK_IDLE  = 5'b00001,
    RK_RD_I  = 5'b00010,
    RK_LAT_I = 5'b00100,
    RK_SCAN  = 5'b01000,
    RK_WR    = 5'b10000
  } rank_state_t;

  rank_state_t       state;
  logic [IW-1:0]     i;
  logic [IW-1:0]     j;
  logic [IW-1:0]     rank;
  logic [KEY_BITS-1:0] cur_key;
  logic              ahead;
  logic              last_j;
  logic              last_i;

  assign ahead  = (key_rdata < cur_key) || ((key_rdata == cur_key) && (j < i));
  assign last_j = (CW'(j) + CW'(1)) == count;
  assign last_i = (CW'(i) + CW'(1)) == count;

  always_comb begin
    case (state)
      RK_RD_I:  key_raddr = i;
      RK_LAT_I: key_raddr = '0;
      RK_SCAN:  key_raddr = IW'(j + IW'(1));
      default:  key_raddr = i;
    endcase
  end

  assign srt_we    = (state == RK_WR);
  assign srt_waddr = rank;
  assign srt_wdata = cur_key;

  assign stat.busy = (state != RK_IDLE);
  assign stat.done = (state == RK_WR) && last_i;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= RK_IDLE;
      i     <= '0;
      j     <= '0;
      rank  <= '0;
    end else begin
      case (state)
        RK_IDLE: begin
          if (start) begin
            i     <= '0;
            state <= RK_RD_I;
          end
        end
        RK_RD_I: begin
          state <= RK_LAT_I;
        end
        RK_LAT_I: begin
          j     <= '0;
          rank  <= '0;
          state <= RK_SCAN;
        end
        RK_SCAN: begin
          rank <= rank + IW'(ahead);
          if (last_j) begin
            state <= RK_WR;
          end else begin
            j <= j + IW'(1);
          end
        end
        RK_WR: begin
          if (last_i) begin
            state <= RK_IDLE;
          end else begin
            i     <= i + IW'(1);
            state <= RK_RD_I;
          end
        end
        default: begin
          state <= RK_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == RK_LAT_I) begin
      cur_key <= key_rdata;
    end
  end

endmodule

/* hw/rtl/rank_enumeration_sorter_core.sv */
// Rank enumeration sorter: stable ascending sort of one batch of keys.
// Load channel (load_valid/load_stall): one key beat per cycle while loading;
// last marks the final key of the batch. Up to MAX_ITEMS keys are kept; keys
// beyond that are ignored and every result of that batch carries dropped.
// Sorted channel (sorted_valid/sorted_stall): after the last beat the block
// emits the kept keys in ascending order, equal keys in arrival order, with
// last_out on the final one.
// For a batch of n kept keys, ranking does for each key one read of the key
// memory, then a scan of all n keys through its single read port, then one
// write of the key into the sorted memory at its rank. Draining reads each
// result from the sorted memory, then loads it into the output register.
// load_stall stays high from the last beat until the final result has been
// loaded into the output register; the next batch may load while that result
// waits. A stall on the sorted channel holds the output register and pauses
// the drain. Reset empties the batch and the output register; no memory
// clearing pass is needed.
`include "rank_enumeration_sorter_core_macros.svh"

module rank_enumeration_sorter_core #(
  parameter int MAX_ITEMS = 16,
  parameter int KEY_BITS  = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            load_valid,
  output logic                            load_stall,
  input  logic [res_pkg::KEY_PORT_W-1:0]  key,
  input  logic                            last,
  output logic                            sorted_valid,
  input  logic                            sorted_stall,
  output logic [res_pkg::KEY_PORT_W-1:0]  sorted_key,
  output logic                            last_out,
  output logic                            dropped
);

  localparam int IW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int PW = res_pkg::KEY_PORT_W;

  typedef enum logic [3:0] {
    ST_LOAD  = 4'b0001,
    ST_RANK  = 4'b0010,
    ST_DR_RD = 4'b0100,
    ST_DR_LD = 4'b1000
  } top_state_t;

  top_state_t              state;
  logic [CW-1:0]           item_count;
  logic                    overflow_flag;
  logic [IW-1:0]           k;
  logic                    load_acc;
  logic                    full;
  logic                    last_k;
  logic [KEY_BITS-1:0]     key_st;
  logic [PW-1:0]           drain_key;
  logic [IW-1:0]           key_raddr;
  logic [KEY_BITS-1:0]     key_rdata;
  logic                    srt_we;
  logic [IW-1:0]           srt_waddr;
  logic [KEY_BITS-1:0]     srt_wdata;
  logic [KEY_BITS-1:0]     srt_rdata;
  res_pkg::res_rank_stat_t rank_stat;

  generate
    if (KEY_BITS <= PW) begin : g_key_narrow
      assign key_st    = key[KEY_BITS-1:0];
      assign drain_key = PW'(srt_rdata);
    end else begin : g_key_wide
      assign key_st    = KEY_BITS'(key);
      assign drain_key = srt_rdata[PW-1:0];
    end
  endgenerate

  assign load_stall = (state != ST_LOAD);
  assign load_acc   = load_valid && !load_stall;
  assign full       = (item_count == CW'(MAX_ITEMS));
  assign last_k     = (CW'(k) + CW'(1)) == item_count;

  res_ram #(.WIDTH(KEY_BITS), .DEPTH(MAX_ITEMS)) u_key_ram (
    .clk   (clk),
    .we    (load_acc && !full),
    .waddr (item_count[IW-1:0]),
    .wdata (key_st),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  res_rank #(.MAX_ITEMS(MAX_ITEMS), .KEY_BITS(KEY_BITS)) u_rank (
    .clk       (clk),
    .rst       (rst),
    .start     (load_acc && last),
    .count     (item_count),
    .key_raddr (key_raddr),
    .key_rdata (key_rdata),
    .srt_we    (srt_we),
    .srt_waddr (srt_waddr),
    .srt_wdata (srt_wdata),
    .stat      (rank_stat)
  );

  res_ram #(.WIDTH(KEY_BITS), .DEPTH(MAX_ITEMS)) u_sorted_ram (
    .clk   (clk),
    .we    (srt_we),
    .waddr (srt_waddr),
    .wdata (srt_wdata),
    .raddr (k),
    .rdata (srt_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      item_count    <= '0;
      overflow_flag <= 1'b0;
      k             <= '0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (load_acc) begin
            if (full) begin
              overflow_flag <= 1'b1;
            end else begin
              item_count <= item_count + CW'(1);
            end
            if (last) begin
              state <= ST_RANK;
            end
          end
        end
        ST_RANK: begin
          if (rank_stat.done) begin
            k     <= '0;
            state <= ST_DR_RD;
          end
        end
        ST_DR_RD: begin
          if (!sorted_valid || !sorted_stall) begin
            state <= ST_DR_LD;
          end
        end
        ST_DR_LD: begin
          if (last_k) begin
            item_count    <= '0;
            overflow_flag <= 1'b0;
            state         <= ST_LOAD;
          end else begin
            k     <= k + IW'(1);
            state <= ST_DR_RD;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sorted_valid <= 1'b0;
    end else if (state == ST_DR_LD) begin
      sorted_valid <= 1'b1;
    end else if (sorted_valid && !sorted_stall) begin
      sorted_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DR_LD) begin
      sorted_key <= drain_key;
      last_out   <= last_k;
      dropped    <= overflow_flag;
    end
  end

  `RES_ASSERT_IMP(a_count_cap, 1'b1, item_count <= CW'(MAX_ITEMS))
  `RES_ASSERT_IMP(a_no_load_while_rank, rank_stat.busy, load_stall)
  `RES_ASSERT_NEXT(a_last_starts_rank, load_acc && last, rank_stat.busy)
  `RES_ASSERT_IMP(a_load_into_free, state == ST_DR_LD, !sorted_valid)

endmodule

/* test/tb_top.sv */
module tb_top;

  localparam int KEY_W     = res_pkg::KEY_PORT_W;
  localparam int BATCH_MAX = 16;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             last;
    logic             lit;
    logic [KEY_W-1:0] lit_key;
  } load_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             fin;
    logic             drop;
  } sorted_beat_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             load_valid = 1'b0;
  logic             load_stall;
  logic [KEY_W-1:0] key = '0;
  logic             last = 1'b0;
  logic             sorted_valid;
  logic             sorted_stall = 1'b0;
  logic [KEY_W-1:0] sorted_key;
  logic             last_out;
  logic             dropped;

  load_item_t       load_q[$];
  load_item_t       cur_item;
  logic [KEY_W-1:0] batch_keys[$];
  logic             batch_overflow = 1'b0;
  sorted_beat_t     pending_sorted[$];
  int               err_count = 0;
  int               send_idle_pct = 0;
  int               recv_stall_pct = 0;
  int               hold_left = 0;

  load_item_t dir_tab [0:24] = '{
    '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
    '{32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF},
    '{32'h8000_0000, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{32'h8000_0000, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0001, 1'b1, 1'b0, 32'h0},
    '{32'hF000_0000, 1'b0, 1'b0, 32'h0},
    '{32'hE000_0001, 1'b0, 1'b0, 32'h0},
    '{32'h0040_0000, 1'b0, 1'b0, 32'h0},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{32'h0040_0000, 1'b0, 1'b0, 32'h0},
    '{32'h5555_5555, 1'b0, 1'b0, 32'h0},
    '{32'hAAAA_AAAA, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0003, 1'b0, 1'b0, 32'h0},
    '{32'h1234_5678, 1'b0, 1'b0, 32'h0},
    '{32'h8765_4321, 1'b0, 1'b0, 32'h0},
    '{32'hFFFF_FFFE, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0002, 1'b0, 1'b0, 32'h0},
    '{32'h3C00_0000, 1'b0, 1'b0, 32'h0},
    '{32'h1234_5678, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0000, 1'b1, 1'b0, 32'h0}
  };

  rank_enumeration_sorter_core dut (
    .clk          (clk),
    .rst          (rst),
    .load_valid   (load_valid),
    .load_stall   (load_stall),
    .key          (key),
    .last         (last),
    .sorted_valid (sorted_valid),
    .sorted_stall (sorted_stall),
    .sorted_key   (sorted_key),
    .last_out     (last_out),
    .dropped      (dropped)
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    err_count++;
  endtask

  // Keep the batch in stable ascending order as keys arrive; on the last key queue the expected sorted beats.
  task automatic absorb_key(input load_item_t it);
    int           pos;
    sorted_beat_t b;
    if (batch_keys.size() < BATCH_MAX) begin
      pos = batch_keys.size();
      while (pos > 0 && batch_keys[pos-1] > it.key) pos--;
      batch_keys.insert(pos, it.key);
    end else begin
      batch_overflow = 1'b1;
    end
    if (it.last) begin
      for (int r = 0; r < batch_keys.size(); r++) begin
        b.key  = it.lit ? it.lit_key : batch_keys[r];
        b.fin  = (r == batch_keys.size() - 1);
        b.drop = batch_overflow;
        pending_sorted.push_back(b);
      end
      batch_keys.delete();
      batch_overflow = 1'b0;
    end
  endtask

  function automatic logic [KEY_W-1:0] pick_key(input int mode);
    logic [KEY_W-1:0] k;
    case (mode)
      0: k = $urandom;
      1: k = $urandom_range(3);
      2: begin
        case ($urandom_range(3))
          0: k = '0;
          1: k = '1;
          2: k = 32'h8000_0000;
          default: k = 32'h7FFF_FFFF;
        endcase
      end
      default: k = {2'($urandom_range(3)), 30'($urandom_range(15))};
    endcase
    return k;
  endfunction

  task automatic queue_batches(input int n_items);
    int queued;
    int sz;
    int mode;
    load_item_t it;
    queued = 0;
    while (queued < n_items) begin
      if ($urandom_range(99) < 12) sz = $urandom_range(20, 17);
      else if ($urandom_range(99) < 15) sz = BATCH_MAX;
      else sz = $urandom_range(BATCH_MAX, 1);
      mode = $urandom_range(3);
      for (int i = 0; i < sz; i++) begin
        it.key     = pick_key($urandom_range(99) < 70 ? mode : $urandom_range(3));
        it.last    = (i == sz - 1);
        it.lit     = 1'b0;
        it.lit_key = '0;
        load_q.push_back(it);
      end
      queued += sz;
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (load_q.size() != 0 || load_valid || pending_sorted.size() != 0);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      load_valid <= 1'b0;
    end else begin
      if (load_valid && !load_stall) absorb_key(cur_item);
      if (!load_valid || !load_stall) begin
        if (load_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_item = load_q.pop_front();
          key        <= cur_item.key;
          last       <= cur_item.last;
          load_valid <= 1'b1;
        end else begin
          load_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    sorted_beat_t exp_beat;
    if (rst) begin
      sorted_stall <= 1'b0;
    end else begin
      if (sorted_valid && !sorted_stall) begin
        if (pending_sorted.size() == 0) begin
          report_mismatch($sformatf("unexpected beat key=%h", sorted_key));
        end else begin
          exp_beat = pending_sorted.pop_front();
          if (sorted_key !== exp_beat.key)
            report_mismatch($sformatf("sorted_key %h, want %h", sorted_key, exp_beat.key));
          if (last_out !== exp_beat.fin)
            report_mismatch($sformatf("last_out %b, want %b", last_out, exp_beat.fin));
          if (dropped !== exp_beat.drop)
            report_mismatch($sformatf("dropped %b, want %b", dropped, exp_beat.drop));
        end
      end
      if (hold_left > 0) begin
        sorted_stall <= 1'b1;
        hold_left    <= hold_left - 1;
      end else begin
        sorted_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < 25; i++) load_q.push_back(dir_tab[i]);
    wait_drained();

    // hold the sorted side so the block fills and stalls its input
    hold_left = 500;
    queue_batches(30);
    wait_drained();

    send_idle_pct  = 88;
    recv_stall_pct = 0;
    queue_batches(30);
    wait_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 88;
    queue_batches(30);
    wait_drained();

    send_idle_pct  = 23;
    recv_stall_pct = 23;
    queue_batches(30);
    wait_drained();

    repeat (60) @(negedge clk);
    if (err_count == 0 && pending_sorted.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/res_pkg.sv
hw/rtl/res_ram.sv
hw/rtl/res_rank.sv
hw/rtl/rank_enumeration_sorter_core.sv
test/tb_top.sv
